[hw/rtl/http_content_length_framer_unit_macros.svh]
// Assertion macros used by the framer back stage (hclf_back).
// Define ASSERT_OFF to compile the checks out.
`ifndef HTTP_CONTENT_LENGTH_FRAMER_UNIT_MACROS_SVH
`define HTTP_CONTENT_LENGTH_FRAMER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define HCLF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HCLF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCLF_ASSERT(lbl, clk, rst_n, prop, msg)
`define HCLF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/hclf_pkg.sv]
`default_nettype none
package hclf_pkg;

  localparam int KEY_LEN   = 16;
  localparam int KEY_IDX_W = $clog2(KEY_LEN);
  localparam int KEY_CNT_W = $clog2(KEY_LEN + 1);

  localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
  };

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;

  localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

  // result event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_HDR_DONE = 3'd1;
  localparam logic [2:0] EV_RSP_DONE = 3'd2;
  localparam logic [2:0] EV_NO_LEN   = 3'd3;
  localparam logic [2:0] EV_OVERFLOW = 3'd4;

  // phase codes
  localparam logic PH_HEADER = 1'b0;
  localparam logic PH_BODY   = 1'b1;

  // terminator progress codes
  localparam logic [1:0] TP_NONE   = 2'd0;
  localparam logic [1:0] TP_CR     = 2'd1;
  localparam logic [1:0] TP_CRLF   = 2'd2;
  localparam logic [1:0] TP_CRLFCR = 2'd3;

  // classified byte, front to back
  typedef struct packed {
    logic [KEY_LEN-1:0] key_hit;
    logic               is_digit;
    logic [3:0]         digit;
    logic               is_cr;
    logic               is_lf;
  } cls_t;

endpackage
`default_nettype wire

[hw/rtl/hclf_front.sv]
`default_nettype none
module hclf_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire [7:0]           in_rx_byte,
  output logic                q_valid,
  output hclf_pkg::cls_t      q_cls,
  input  wire                 q_pop
);

  hclf_pkg::cls_t cls;
  hclf_pkg::cls_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           push;

  always_comb begin
    for (int i = 0; i < hclf_pkg::KEY_LEN; i++) begin
      cls.key_hit[i] = (in_rx_byte == hclf_pkg::KEY_TEXT[i]);
    end
    cls.is_digit = (in_rx_byte >= hclf_pkg::CHAR_0) && (in_rx_byte <= hclf_pkg::CHAR_9);
    cls.digit    = in_rx_byte[3:0];
    cls.is_cr    = (in_rx_byte == hclf_pkg::CHAR_CR);
    cls.is_lf    = (in_rx_byte == hclf_pkg::CHAR_LF);
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_cls    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 2'd1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/hclf_back.sv]
`default_nettype none
`include "http_content_length_framer_unit_macros.svh"
module hclf_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  input  hclf_pkg::cls_t      q_cls,
  output logic                q_pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [2:0]          out_event_res,
  output logic                out_in_body,
  output logic [31:0]         out_body_length,
  output logic [15:0]         out_responses_done
);

  logic                             out_valid_r;
  logic [2:0]                       ev_r, ev_nxt;
  logic                             in_body_r, in_body_nxt;
  logic                             phase_r, phase_nxt;
  logic [hclf_pkg::KEY_IDX_W-1:0]   match_r, match_nxt;
  logic [1:0]                       term_r, term_nxt;
  logic                             seen_r, seen_nxt;
  logic                             digits_r, digits_nxt;
  logic [31:0]                      len_r, len_nxt;
  logic [31:0]                      rem_r, rem_nxt;
  logic [15:0]                      cnt_r, cnt_nxt;

  logic [hclf_pkg::KEY_CNT_W-1:0]   mi;
  logic [35:0]                      prod;
  logic [31:0]                      rem_dec;
  logic                             hdr_end;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // len*10 + digit, upper bits flag overflow
  assign prod = ({4'd0, len_r} << 3) + ({4'd0, len_r} << 1) + {32'd0, q_cls.digit};
  assign rem_dec = rem_r - {31'd0, (rem_r != 32'd0)};

  always_comb begin
    ev_nxt      = hclf_pkg::EV_NONE;
    in_body_nxt = 1'b0;
    phase_nxt   = phase_r;
    match_nxt   = match_r;
    term_nxt    = term_r;
    seen_nxt    = seen_r;
    digits_nxt  = digits_r;
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    mi          = '0;
    hdr_end     = 1'b0;

    if (phase_r == hclf_pkg::PH_BODY) begin
      in_body_nxt = 1'b1;
      rem_nxt     = rem_dec;
      if (rem_dec == 32'd0) begin
        ev_nxt     = hclf_pkg::EV_RSP_DONE;
        cnt_nxt    = cnt_r + 16'd1;
        phase_nxt  = hclf_pkg::PH_HEADER;
        match_nxt  = '0;
        term_nxt   = hclf_pkg::TP_NONE;
        seen_nxt   = 1'b0;
        digits_nxt = 1'b0;
      end
    end else begin
      if (digits_r) begin
        if (q_cls.is_digit) begin
          if (|prod[35:32]) begin
            len_nxt = hclf_pkg::LEN_MAX;
            ev_nxt  = hclf_pkg::EV_OVERFLOW;
          end else begin
            len_nxt = prod[31:0];
          end
        end else begin
          digits_nxt = 1'b0;
        end
      end

      // key matcher, first match per header only
      if (!seen_r) begin
        if (q_cls.key_hit[match_r]) begin
          mi = {1'b0, match_r} + 1'b1;
        end else begin
          mi = q_cls.key_hit[0] ? hclf_pkg::KEY_CNT_W'(1) : '0;
        end
        if (mi == hclf_pkg::KEY_CNT_W'(hclf_pkg::KEY_LEN)) begin
          seen_nxt   = 1'b1;
          digits_nxt = 1'b1;
          len_nxt    = 32'd0;
          match_nxt  = '0;
        end else begin
          match_nxt  = mi[hclf_pkg::KEY_IDX_W-1:0];
        end
      end

      if (q_cls.is_cr) begin
        term_nxt = (term_r == hclf_pkg::TP_CRLF) ? hclf_pkg::TP_CRLFCR : hclf_pkg::TP_CR;
      end else if (q_cls.is_lf) begin
        if (term_r == hclf_pkg::TP_CR) begin
          term_nxt = hclf_pkg::TP_CRLF;
        end else begin
          term_nxt = hclf_pkg::TP_NONE;
          hdr_end  = (term_r == hclf_pkg::TP_CRLFCR);
        end
      end else begin
        term_nxt = hclf_pkg::TP_NONE;
      end

      if (hdr_end) begin
        if (!seen_nxt) begin
          ev_nxt  = hclf_pkg::EV_NO_LEN;
          len_nxt = 32'd0;
        end else if (len_nxt == 32'd0) begin
          ev_nxt  = hclf_pkg::EV_RSP_DONE;
          cnt_nxt = cnt_r + 16'd1;
        end else begin
          ev_nxt    = hclf_pkg::EV_HDR_DONE;
          rem_nxt   = len_nxt;
          phase_nxt = hclf_pkg::PH_BODY;
        end
        match_nxt  = '0;
        term_nxt   = hclf_pkg::TP_NONE;
        seen_nxt   = 1'b0;
        digits_nxt = 1'b0;
      end
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    if (q_pop) begin
      ev_r      <= ev_nxt;
      in_body_r <= in_body_nxt;
    end
  end

  // state advances only when a result is loaded, so length and count match it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= hclf_pkg::PH_HEADER;
      match_r     <= '0;
      term_r      <= hclf_pkg::TP_NONE;
      seen_r      <= 1'b0;
      digits_r    <= 1'b0;
      len_r       <= 32'd0;
      rem_r       <= 32'd0;
      cnt_r       <= 16'd0;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        match_r     <= match_nxt;
        term_r      <= term_nxt;
        seen_r      <= seen_nxt;
        digits_r    <= digits_nxt;
        len_r       <= len_nxt;
        rem_r       <= rem_nxt;
        cnt_r       <= cnt_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = ev_r;
  assign out_in_body        = in_body_r;
  assign out_body_length    = len_r;
  assign out_responses_done = cnt_r;

  `HCLF_ASSERT_ALWAYS(a_rst_clears, clk, !rst_n |=> !out_valid_r && (phase_r == hclf_pkg::PH_HEADER), "reset left result or body phase")
  `HCLF_ASSERT(a_body_rem, clk, rst_n, (phase_r == hclf_pkg::PH_BODY) |-> (rem_r != 32'd0), "body phase with nothing remaining")
  `HCLF_ASSERT(a_cnt_hold, clk, rst_n, (q_pop && (ev_nxt != hclf_pkg::EV_RSP_DONE)) |=> (cnt_r == $past(cnt_r)), "count moved without completion")
  `HCLF_ASSERT(a_seen_idle, clk, rst_n, seen_r |-> (match_r == '0), "matcher advanced after length seen")
  `HCLF_ASSERT(a_digits_seen, clk, rst_n, digits_r |-> seen_r, "digits taken without key match")

endmodule
`default_nettype wire

[hw/rtl/http_content_length_framer_unit.sv]
// Content-Length framer for a received HTTP/1.1 response byte stream.
// Input channel (in_valid/in_ready/in_rx_byte): one stream byte per beat.
// Result channel (out_valid/out_ready/out_*): exactly one result beat per
// input beat, in order: event code, body flag, the parsed length and the
// running count of completed responses (both as left after that byte).
// A front stage classifies each byte (key letter hits, digit, CR, LF) into a
// two-entry queue; the back stage runs the header matcher, the length
// accumulator, the CRLFCRLF detector and the body countdown, and holds the
// result in an output register.
// Each taken byte is registered in the queue, and then its result in the output
// register, from which its result beat leaves.
// Throughput: one byte per cycle while out_ready stays high; the back stage
// state update (one 36-bit multiply-by-ten add) sets the cycle.
// When the receiver stalls the output register holds its beat, the queue
// fills both of its entries, and in_ready drops.
// Reset (rst_n low, synchronous) empties queue and output register and puts
// the block in the header phase with zero length and zero count.
`default_nettype none
module http_content_length_framer_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [7:0]   in_rx_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_event_res,
  output logic        out_in_body,
  output logic [31:0] out_body_length,
  output logic [15:0] out_responses_done
);

  logic           q_valid;
  logic           q_pop;
  hclf_pkg::cls_t q_cls;

  hclf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_valid    (q_valid),
    .q_cls      (q_cls),
    .q_pop      (q_pop)
  );

  hclf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_cls              (q_cls),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_in_body        (out_in_body),
    .out_body_length    (out_body_length),
    .out_responses_done (out_responses_done)
  );

endmodule
`default_nettype wire

[tb/http_content_length_framer_unit_tb.sv]
module http_content_length_framer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam string CRLF = "\015\012";
  localparam string LEN_KEY = "Content-Length: ";

  typedef struct packed {
    logic [2:0]  ev_code;
    logic        body_flag;
    logic [31:0] body_len;
    logic [15:0] rsp_count;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_res;
  logic        out_in_body;
  logic [31:0] out_body_length;
  logic [15:0] out_responses_done;

  http_content_length_framer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_in_body       (out_in_body),
    .out_body_length   (out_body_length),
    .out_responses_done(out_responses_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // framer state as the predictor sees it
  logic        hdr_phase = hclf_pkg::PH_HEADER;
  logic [4:0]  key_pos = '0;
  logic [1:0]  crlf_state = hclf_pkg::TP_NONE;
  logic        key_found = 1'b0;
  logic        digit_run = 1'b0;
  logic [31:0] parsed_len = '0;
  logic [31:0] body_left = '0;
  logic [15:0] done_count = '0;

  frame_result_t expected_results[$];

  int error_count = 0;
  int bytes_sent = 0;
  int no_len_count = 0;
  int overflow_count = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;

  function automatic void clear_header();
    key_pos = '0;
    crlf_state = hclf_pkg::TP_NONE;
    key_found = 1'b0;
    digit_run = 1'b0;
  endfunction

  function automatic frame_result_t frame_byte(input logic [7:0] b);
    frame_result_t r;
    logic [35:0]   wide;
    logic [4:0]    pos;
    logic          hdr_end;
    r.ev_code = hclf_pkg::EV_NONE;
    r.body_flag = 1'b0;
    hdr_end = 1'b0;
    if (hdr_phase == hclf_pkg::PH_BODY) begin
      r.body_flag = 1'b1;
      if (body_left != 32'd0) body_left = body_left - 32'd1;
      if (body_left == 32'd0) begin
        r.ev_code = hclf_pkg::EV_RSP_DONE;
        done_count = done_count + 16'd1;
        hdr_phase = hclf_pkg::PH_HEADER;
        clear_header();
      end
    end else begin
      if (digit_run) begin
        if (b >= hclf_pkg::CHAR_0 && b <= hclf_pkg::CHAR_9) begin
          wide = {4'd0, parsed_len} * 36'd10 + {28'd0, b - hclf_pkg::CHAR_0};
          // saturate instead of wrapping
          if (wide > {4'd0, hclf_pkg::LEN_MAX}) begin
            parsed_len = hclf_pkg::LEN_MAX;
            r.ev_code = hclf_pkg::EV_OVERFLOW;
          end else begin
            parsed_len = wide[31:0];
          end
        end else begin
          digit_run = 1'b0;
        end
      end
      // only the first key in a header counts
      if (!key_found) begin
        pos = (key_pos >= hclf_pkg::KEY_LEN) ? 5'd0 : key_pos;
        if (b == LEN_KEY[pos]) pos = pos + 5'd1;
        else pos = (b == LEN_KEY[0]) ? 5'd1 : 5'd0;
        if (pos == hclf_pkg::KEY_LEN) begin
          key_found = 1'b1;
          digit_run = 1'b1;
          parsed_len = '0;
          pos = '0;
        end
        key_pos = pos;
      end
      if (b == hclf_pkg::CHAR_CR) begin
        crlf_state = (crlf_state == hclf_pkg::TP_CRLF) ? hclf_pkg::TP_CRLFCR : hclf_pkg::TP_CR;
      end else if (b == hclf_pkg::CHAR_LF) begin
        if (crlf_state == hclf_pkg::TP_CR) begin
          crlf_state = hclf_pkg::TP_CRLF;
        end else if (crlf_state == hclf_pkg::TP_CRLFCR) begin
          hdr_end = 1'b1;
          crlf_state = hclf_pkg::TP_NONE;
        end else begin
          crlf_state = hclf_pkg::TP_NONE;
        end
      end else begin
        crlf_state = hclf_pkg::TP_NONE;
      end
      if (hdr_end) begin
        if (!key_found) begin
          r.ev_code = hclf_pkg::EV_NO_LEN;
          parsed_len = '0;
        end else if (parsed_len == 32'd0) begin
          r.ev_code = hclf_pkg::EV_RSP_DONE;
          done_count = done_count + 16'd1;
        end else begin
          r.ev_code = hclf_pkg::EV_HDR_DONE;
          body_left = parsed_len;
          hdr_phase = hclf_pkg::PH_BODY;
        end
        clear_header();
      end
    end
    r.body_len = parsed_len;
    r.rsp_count = done_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 40)
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Call at a rising edge; returns at the edge that accepts the beat.
  task automatic send_byte(input logic [7:0] b);
    frame_result_t want;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    want = frame_byte(b);
    if (want.ev_code == hclf_pkg::EV_NO_LEN) no_len_count++;
    if (want.ev_code == hclf_pkg::EV_OVERFLOW) overflow_count++;
    expected_results.insert(expected_results.size(), want);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_response();
    string hdr;
    int    pick;
    hdr = "";
    if ($urandom_range(3) == 0) hdr = {"HTTP/1.1 200 OK", CRLF};
    // near miss that forces the key matcher to restart
    if ($urandom_range(4) == 0) hdr = {hdr, "CContent-Lengt: 9", CRLF};
    pick = $urandom_range(99);
    if (pick < 10)
      hdr = {hdr, "content-length: 5", CRLF};
    else if (pick < 16)
      hdr = {hdr, LEN_KEY, "0", CRLF};
    else if (pick < 20)
      hdr = {hdr, LEN_KEY, CRLF};
    else if (pick < 24)
      hdr = {hdr, LEN_KEY, " 7", CRLF};
    else if (pick < 32)
      hdr = {hdr, LEN_KEY, $sformatf("%0dz4", $urandom_range(1, 30)), CRLF};
    else if (pick < 38)
      hdr = {hdr, LEN_KEY, $sformatf("00%0d", $urandom_range(1, 9)), CRLF};
    else
      hdr = {hdr, LEN_KEY, $sformatf("%0d", $urandom_range(1, 40)), CRLF};
    if ($urandom_range(6) == 0) hdr = {hdr, LEN_KEY, "999", CRLF};
    if ($urandom_range(9) == 0) hdr = {hdr, "\012\015\015\012"};
    hdr = {hdr, CRLF};
    send_text(hdr);
    while (hdr_phase == hclf_pkg::PH_BODY) send_byte(8'($urandom_range(255)));
  endtask

  task automatic test_header_without_length();
    send_byte(8'h00);
    send_text({CRLF, CRLF});
  endtask

  task automatic test_key_restart_and_body();
    send_text({"C", LEN_KEY, "1", CRLF, CRLF});
    send_byte(8'hFF);
  endtask

  task automatic test_random_traffic(input int gap, input int stall, input int n_bytes);
    int start;
    start = bytes_sent;
    send_gap_pct = gap;
    stall_pct = stall;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
      send_response();
    end
  endtask

  // Leaves the framer in a body it will never finish; run it last.
  task automatic test_length_saturation();
    send_gap_pct = 0;
    stall_pct = 0;
    send_text({LEN_KEY, "4294967295", "07", CRLF, CRLF});
    repeat (30) send_byte(8'($urandom_range(255)));
  endtask

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", 32'(out_event_res), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_event_res !== want.ev_code)
          report_mismatch("event_res", 32'(out_event_res), 32'(want.ev_code));
        if (out_in_body !== want.body_flag)
          report_mismatch("in_body", 32'(out_in_body), 32'(want.body_flag));
        if (out_body_length !== want.body_len)
          report_mismatch("body_length", out_body_length, want.body_len);
        if (out_responses_done !== want.rsp_count)
          report_mismatch("responses_done", 32'(out_responses_done), 32'(want.rsp_count));
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_header_without_length();
    test_key_restart_and_body();
    test_random_traffic(0, 0, 175);
    test_random_traffic(60, 0, 175);
    test_random_traffic(0, 60, 175);
    test_random_traffic(6, 6, 175);
    test_length_saturation();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Streamed %0d bytes: %0d responses completed, %0d headers without length,",
             bytes_sent, done_count, no_len_count);
    $display("%0d saturating digits, with sender gaps and receiver stalls in turn",
             overflow_count);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/hclf_pkg.sv
hw/rtl/hclf_front.sv
hw/rtl/hclf_back.sv
hw/rtl/http_content_length_framer_unit.sv
tb/http_content_length_framer_unit_tb.sv
